[hw/rtl/rc4v_pkg.sv]
// Shared constants and types for the RC4-variant stream cipher block.
`timescale 1ns / 1ps
package rc4v_pkg;

  // Byte and field widths
  localparam int BYTE_W = 8;
  localparam int CMD_W  = 2;
  localparam int LEN_W  = 9;

  // Key store sizing
  localparam int KEY_MAX_BYTES = 256;
  localparam int KEY_AW        = $clog2(KEY_MAX_BYTES);

  // S-box sizing
  localparam int SBOX_DEPTH = 256;
  localparam int SBOX_AW    = $clog2(SBOX_DEPTH);

  // Command codes
  localparam logic [CMD_W-1:0] CMD_LOAD  = 2'd0;
  localparam logic [CMD_W-1:0] CMD_BEGIN = 2'd1;
  localparam logic [CMD_W-1:0] CMD_ENC   = 2'd2;
  localparam logic [CMD_W-1:0] CMD_DEC   = 2'd3;

  // One cycle of S-box port requests from the sequencer
  typedef struct packed {
    logic               clear;
    logic               rd_en;
    logic [SBOX_AW-1:0] rd_addr;
    logic               wr_en;
    logic [SBOX_AW-1:0] wr_addr;
    logic [BYTE_W-1:0]  wr_data;
  } sbox_req_t;

endpackage

[hw/rtl/rc4v_in_if.sv]
// Input item channel: command, key index and data byte.
`timescale 1ns / 1ps
interface rc4v_in_if;
  logic                        valid;
  logic                        ready;
  logic [rc4v_pkg::CMD_W-1:0]  command;
  logic [rc4v_pkg::BYTE_W-1:0] key_index;
  logic [rc4v_pkg::BYTE_W-1:0] data_byte;

  modport source (output valid, output command, output key_index, output data_byte,
                  input ready);
  modport sink (input valid, input command, input key_index, input data_byte,
                output ready);
endinterface

[hw/rtl/rc4v_out_if.sv]
// Result item channel: one output byte.
`timescale 1ns / 1ps
interface rc4v_out_if;
  logic                        valid;
  logic                        ready;
  logic [rc4v_pkg::BYTE_W-1:0] out_byte;

  modport source (output valid, output out_byte, input ready);
  modport sink (input valid, input out_byte, output ready);
endinterface

[hw/rtl/rc4v_cfg_if.sv]
// Configuration write channel: key length register.
`timescale 1ns / 1ps
interface rc4v_cfg_if;
  logic                       valid;
  logic                       ready;
  logic [rc4v_pkg::LEN_W-1:0] key_length;

  modport source (output valid, output key_length, input ready);
  modport sink (input valid, input key_length, output ready);
endinterface

[hw/rtl/rc4_variant_stream_cipher.sv]
// Top level of the RC4-variant stream cipher: sequencer, key store and S-box.
// Encrypt/decrypt: result registered after the RD_J, SWAP and WR_J states; next item accepted
// on return to idle (one S-box read/write port pair shared by i, j, swap and t lookups).
// Begin: next item accepted after 256 key-schedule steps, each through K_RD, K_J, K_SW and
// K_WJ. Load: the block stays ready.
// A waiting result does not block the sequencer until the next result is due.
// Reset (rst_n low, synchronous): indices 0, key length 1, S-box reads as identity
// at once via per-entry valid bits; key store contents undefined until loaded.
`timescale 1ns / 1ps
module rc4_variant_stream_cipher (
  input logic       clk,
  input logic       rst_n,
  rc4v_in_if.sink   in_if,
  rc4v_out_if.source out_if,
  rc4v_cfg_if.sink  cfg_if
);

  // Sequencer states
  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_RD_J = 3'd1;
  localparam logic [2:0] ST_SWAP = 3'd2;
  localparam logic [2:0] ST_WR_J = 3'd3;
  localparam logic [2:0] ST_K_RD = 3'd4;
  localparam logic [2:0] ST_K_J  = 3'd5;
  localparam logic [2:0] ST_K_SW = 3'd6;
  localparam logic [2:0] ST_K_WJ = 3'd7;

  logic [2:0]                      state_r, state_nxt;
  logic [rc4v_pkg::SBOX_AW-1:0]    i_r, i_nxt;
  logic [rc4v_pkg::SBOX_AW-1:0]    j_r, j_nxt;
  logic [rc4v_pkg::BYTE_W-1:0]     a_r, a_nxt;
  logic [rc4v_pkg::BYTE_W-1:0]     b_r, b_nxt;
  logic [rc4v_pkg::BYTE_W-1:0]     t_r, t_nxt;
  logic [rc4v_pkg::KEY_AW-1:0]     kp_r, kp_nxt;
  logic [rc4v_pkg::BYTE_W-1:0]     dat_r, dat_nxt;
  logic                            dec_r, dec_nxt;
  logic                            out_valid_r, out_valid_nxt;
  logic [rc4v_pkg::BYTE_W-1:0]     out_byte_r, out_byte_nxt;
  logic [rc4v_pkg::LEN_W-1:0]      key_length_r;

  logic [rc4v_pkg::LEN_W-1:0]      len_eff;
  logic [rc4v_pkg::LEN_W-1:0]      kp_inc;
  logic                            key_in_range;
  logic                            key_we;
  logic                            key_re;
  logic [rc4v_pkg::BYTE_W-1:0]     key_rdata;
  logic [rc4v_pkg::BYTE_W-1:0]     sb_rd_data;
  logic [rc4v_pkg::BYTE_W-1:0]     ks_byte;
  logic [rc4v_pkg::SBOX_AW-1:0]    i_inc;
  logic [rc4v_pkg::SBOX_AW-1:0]    j_gen;
  logic [rc4v_pkg::SBOX_AW-1:0]    j_ks;
  logic [rc4v_pkg::BYTE_W-1:0]     t_sum;
  rc4v_pkg::sbox_req_t             sreq;

  // S-box and key store
  rc4v_sbox u_sbox (
    .clk     (clk),
    .rst_n   (rst_n),
    .req     (sreq),
    .rd_data (sb_rd_data)
  );

  rc4v_ram #(
    .WIDTH (rc4v_pkg::BYTE_W),
    .DEPTH (rc4v_pkg::KEY_MAX_BYTES)
  ) u_key_ram (
    .clk   (clk),
    .we    (key_we),
    .waddr (in_if.key_index[rc4v_pkg::KEY_AW-1:0]),
    .wdata (in_if.data_byte),
    .re    (key_re),
    .raddr (kp_r),
    .rdata (key_rdata)
  );

  // Effective key length: zero acts as one, clamp at the store size
  always_comb begin
    priority if (key_length_r == '0) begin
      len_eff = rc4v_pkg::LEN_W'(1);
    end else if (key_length_r > rc4v_pkg::LEN_W'(rc4v_pkg::KEY_MAX_BYTES)) begin
      len_eff = rc4v_pkg::LEN_W'(rc4v_pkg::KEY_MAX_BYTES);
    end else begin
      len_eff = key_length_r;
    end
  end

  assign kp_inc       = rc4v_pkg::LEN_W'(kp_r) + rc4v_pkg::LEN_W'(1);
  assign key_in_range = rc4v_pkg::LEN_W'(in_if.key_index) <
                        rc4v_pkg::LEN_W'(rc4v_pkg::KEY_MAX_BYTES);

  // Shared adders
  assign i_inc = i_r + rc4v_pkg::SBOX_AW'(1);
  assign j_gen = j_r + sb_rd_data;
  assign j_ks  = j_r + sb_rd_data + key_rdata;
  assign t_sum = a_r + sb_rd_data;

  // Keystream byte, forwarding the swapped entries when t hits i or j
  always_comb begin
    priority if (t_r == j_r) begin
      ks_byte = a_r;
    end else if (t_r == i_r) begin
      ks_byte = b_r;
    end else begin
      ks_byte = sb_rd_data;
    end
  end

  assign in_if.ready = (state_r == ST_IDLE);
  assign cfg_if.ready = 1'b1;
  assign out_if.valid = out_valid_r;
  assign out_if.out_byte = out_byte_r;

  // Sequencer
  always_comb begin
    state_nxt     = state_r;
    i_nxt         = i_r;
    j_nxt         = j_r;
    a_nxt         = a_r;
    b_nxt         = b_r;
    t_nxt         = t_r;
    kp_nxt        = kp_r;
    dat_nxt       = dat_r;
    dec_nxt       = dec_r;
    out_byte_nxt  = out_byte_r;
    out_valid_nxt = out_valid_r && !out_if.ready;
    key_we        = 1'b0;
    key_re        = 1'b0;
    sreq          = '0;

    unique case (state_r)
      ST_IDLE: begin
        if (in_if.valid) begin
          unique case (in_if.command)
            rc4v_pkg::CMD_LOAD: begin
              key_we = key_in_range;
            end
            rc4v_pkg::CMD_BEGIN: begin
              sreq.clear = 1'b1;
              i_nxt      = '0;
              j_nxt      = '0;
              kp_nxt     = '0;
              state_nxt  = ST_K_RD;
            end
            rc4v_pkg::CMD_ENC, rc4v_pkg::CMD_DEC: begin
              i_nxt        = i_inc;
              sreq.rd_en   = 1'b1;
              sreq.rd_addr = i_inc;
              dat_nxt      = in_if.data_byte;
              dec_nxt      = (in_if.command == rc4v_pkg::CMD_DEC);
              state_nxt    = ST_RD_J;
            end
            default: begin
              state_nxt = ST_IDLE;
            end
          endcase
        end
      end

      // a = S[i]; j += a; fetch S[j]
      ST_RD_J: begin
        a_nxt        = sb_rd_data;
        j_nxt        = j_gen;
        sreq.rd_en   = 1'b1;
        sreq.rd_addr = j_gen;
        state_nxt    = ST_SWAP;
      end

      // b = S[j]; S[i] = b; t = a + b; fetch S[t]
      ST_SWAP: begin
        b_nxt        = sb_rd_data;
        t_nxt        = t_sum;
        sreq.wr_en   = 1'b1;
        sreq.wr_addr = i_r;
        sreq.wr_data = sb_rd_data;
        sreq.rd_en   = 1'b1;
        sreq.rd_addr = t_sum;
        state_nxt    = ST_WR_J;
      end

      // S[j] = a; form result once the output slot is free
      ST_WR_J: begin
        sreq.wr_en   = 1'b1;
        sreq.wr_addr = j_r;
        sreq.wr_data = a_r;
        if (!out_valid_r || out_if.ready) begin
          out_valid_nxt = 1'b1;
          out_byte_nxt  = dec_r ? ((dat_r - t_r) ^ ks_byte) : ((dat_r ^ ks_byte) + t_r);
          state_nxt     = ST_IDLE;
        end
      end

      // Key schedule: fetch S[n] and key byte
      ST_K_RD: begin
        sreq.rd_en   = 1'b1;
        sreq.rd_addr = i_r;
        key_re       = 1'b1;
        state_nxt    = ST_K_J;
      end

      // j += S[n] + key; fetch S[j]
      ST_K_J: begin
        a_nxt        = sb_rd_data;
        j_nxt        = j_ks;
        sreq.rd_en   = 1'b1;
        sreq.rd_addr = j_ks;
        state_nxt    = ST_K_SW;
      end

      // S[n] = S[j]
      ST_K_SW: begin
        sreq.wr_en   = 1'b1;
        sreq.wr_addr = i_r;
        sreq.wr_data = sb_rd_data;
        state_nxt    = ST_K_WJ;
      end

      // S[j] = old S[n]; step n and the key pointer
      ST_K_WJ: begin
        sreq.wr_en   = 1'b1;
        sreq.wr_addr = j_r;
        sreq.wr_data = a_r;
        i_nxt        = i_inc;
        kp_nxt       = (kp_inc >= len_eff) ? '0 : kp_inc[rc4v_pkg::KEY_AW-1:0];
        if (i_r == rc4v_pkg::SBOX_AW'(rc4v_pkg::SBOX_DEPTH - 1)) begin
          j_nxt     = '0;
          state_nxt = ST_IDLE;
        end else begin
          state_nxt = ST_K_RD;
        end
      end

      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      i_r          <= '0;
      j_r          <= '0;
      out_valid_r  <= 1'b0;
      key_length_r <= rc4v_pkg::LEN_W'(1);
    end else begin
      state_r     <= state_nxt;
      i_r         <= i_nxt;
      j_r         <= j_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_if.valid) begin
        key_length_r <= cfg_if.key_length;
      end
    end
  end

  // Datapath registers
  always_ff @(posedge clk) begin
    a_r        <= a_nxt;
    b_r        <= b_nxt;
    t_r        <= t_nxt;
    kp_r       <= kp_nxt;
    dat_r      <= dat_nxt;
    dec_r      <= dec_nxt;
    out_byte_r <= out_byte_nxt;
  end

endmodule

[hw/rtl/rc4v_ram.sv]
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps
module rc4v_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  // Write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Read port, read-first, holds when idle
  always_ff @(posedge clk) begin
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

[hw/rtl/rc4v_sbox.sv]
// S-box store: RAM plus per-entry valid bits; unwritten entries read as identity.
`timescale 1ns / 1ps
module rc4v_sbox (
  input  logic                               clk,
  input  logic                               rst_n,
  input  rc4v_pkg::sbox_req_t                req,
  output logic [rc4v_pkg::BYTE_W-1:0]        rd_data
);

  logic [rc4v_pkg::SBOX_DEPTH-1:0] valid_r;
  logic                            rd_vld_r;
  logic [rc4v_pkg::SBOX_AW-1:0]    rd_addr_r;
  logic [rc4v_pkg::BYTE_W-1:0]     ram_q;

  rc4v_ram #(
    .WIDTH (rc4v_pkg::BYTE_W),
    .DEPTH (rc4v_pkg::SBOX_DEPTH)
  ) u_ram (
    .clk   (clk),
    .we    (req.wr_en),
    .waddr (req.wr_addr),
    .wdata (req.wr_data),
    .re    (req.rd_en),
    .raddr (req.rd_addr),
    .rdata (ram_q)
  );

  // Valid bits: reset or clear brings back the identity permutation
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
    end else if (req.clear) begin
      valid_r <= '0;
    end else if (req.wr_en) begin
      valid_r[req.wr_addr] <= 1'b1;
    end
  end

  // Track the valid flag and address alongside the registered read
  always_ff @(posedge clk) begin
    if (req.rd_en) begin
      rd_vld_r  <= valid_r[req.rd_addr];
      rd_addr_r <= req.rd_addr;
    end
  end

  assign rd_data = rd_vld_r ? ram_q : rd_addr_r;

endmodule

[hw/rtl/rc4v_checker.sv]
// Port-level checks for the RC4-variant stream cipher, bound to the top level.
`timescale 1ns / 1ps
module rc4v_checker (
  input logic                       clk,
  input logic                       rst_n,
  input logic                       in_valid,
  input logic                       in_ready,
  input logic [rc4v_pkg::CMD_W-1:0] in_command,
  input logic                       out_valid,
  input logic                       out_ready,
  input logic [rc4v_pkg::BYTE_W-1:0] out_byte
);

  // A stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_byte))
    else $error("result changed while stalled");

  // A key load leaves the block ready
  a_load_ready: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && in_command == rc4v_pkg::CMD_LOAD |=> in_ready)
    else $error("busy after key load");

  // Begin, encrypt and decrypt occupy the sequencer
  a_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && in_command != rc4v_pkg::CMD_LOAD |=> !in_ready)
    else $error("ready right after a multi-cycle item");

  // A fresh result follows an accepted encrypt or decrypt through the RD_J, SWAP and WR_J states
  a_out_origin: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(in_valid && in_ready &&
      (in_command == rc4v_pkg::CMD_ENC || in_command == rc4v_pkg::CMD_DEC), 4))
    else $error("result without matching data item");

endmodule

bind rc4_variant_stream_cipher rc4v_checker u_rc4v_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_valid   (in_if.valid),
  .in_ready   (in_if.ready),
  .in_command (in_if.command),
  .out_valid  (out_if.valid),
  .out_ready  (out_if.ready),
  .out_byte   (out_if.out_byte)
);
